// ===== hw/rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list: capacity,
// request codes, cell commands and field widths.
// ----------------------------------------------------------------------------
package pal_pkg;

    // list geometry
    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = 7;
    localparam int POS_W     = 8;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 3;

    // read-out tree: taps are or-ed in groups, one register per group
    localparam int GROUP     = 8;
    localparam int NGROUPS   = CAPACITY / GROUP;

    // request codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

    // commands broadcast to the cell row
    localparam logic [2:0] CELL_HOLD = 3'd0;
    localparam logic [2:0] CELL_INS  = 3'd1;
    localparam logic [2:0] CELL_REM  = 3'd2;
    localparam logic [2:0] CELL_SET  = 3'd3;
    localparam logic [2:0] CELL_GET  = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of signed 32-bit entries addressed by 1-based
// position, built as a row of shift cells with a registered read-out tree.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | word
//  --------+----------------------------------+----------------------------------
//  in      | in_valid in_ready                | action, position, value
//  out     | out_valid out_ready              | ok, read_value, count, empty_res
//
//  one word is accepted per cycle while in_ready is high; two register stages:
//  the word is registered into stage one, then into the output register
//  all cells shift or write in the accept cycle, so back-to-back requests see
//  the updated list; a get reads through an or tree of 8-slot groups, one
//  register per group, then a final or into the output register
//  reset clears the count and both pipeline valids; entries are not cleared
//  an output stall holds the pipeline and drops in_ready once it is full
module positional_array_list
    import pal_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ACT_W-1:0]         action,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     ok,
    output logic signed [DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]         count,
    output logic                     empty_res
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_ok_reg;
    logic [CNT_W-1:0]  s1_count_reg;
    logic [DATA_W-1:0] s1_part_reg [NGROUPS];
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              ok_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic [CNT_W-1:0]  count_out_reg;

    logic              in_acc;
    logic              s1_adv;
    logic              req_ok;
    logic [POS_W-1:0]  cnt_ext;
    logic              pos_in_list;
    logic              pos_insertable;
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_tap  [CAPACITY];
    logic [DATA_W-1:0] group_or  [NGROUPS];
    logic [DATA_W-1:0] final_or;

    // handshake and pipeline advance
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    // request check against current count
    assign cnt_ext        = POS_W'(count_reg);
    assign pos_in_list    = (position != '0) && (position <= cnt_ext);
    assign pos_insertable = (position != '0) && (position <= cnt_ext + POS_W'(1))
                            && (count_reg < CNT_W'(CAPACITY));

    // decode request into a cell command and the new count
    always_comb
    begin
        req_ok     = 1'b0;
        count_next = count_reg;
        cmd.op     = CELL_HOLD;
        cmd.idx    = IDX_W'(position - POS_W'(1));
        cmd.value  = value;
        if (in_acc)
        begin
            case (action)
                ACT_INSERT:
                begin
                    if (pos_insertable)
                    begin
                        req_ok     = 1'b1;
                        cmd.op     = CELL_INS;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_REMOVE:
                begin
                    if (pos_in_list)
                    begin
                        req_ok     = 1'b1;
                        cmd.op     = CELL_REM;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                ACT_GET:
                begin
                    if (pos_in_list)
                    begin
                        req_ok = 1'b1;
                        cmd.op = CELL_GET;
                    end
                end
                ACT_SET:
                begin
                    if (pos_in_list)
                    begin
                        req_ok = 1'b1;
                        cmd.op = CELL_SET;
                    end
                end
                ACT_CLEAR:
                begin
                    req_ok     = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    req_ok = 1'b0;
                end
            endcase
        end
    end

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        pal_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .cell_idx   (IDX_W'(g)),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[g]),
            .tap        (cell_tap[g])
        );
    end

    // first level of the read tree: or of each group of taps
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_or[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                group_or[g] = group_or[g] | cell_tap[g*GROUP + j];
            end
        end
    end

    // second level of the read tree
    always_comb
    begin
        final_or = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            final_or = final_or | s1_part_reg[g];
        end
    end

    // pipeline valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ok_reg    <= req_ok;
            s1_count_reg <= count_next;
            for (int g = 0; g < NGROUPS; g++)
            begin
                s1_part_reg[g] <= group_or[g];
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            ok_reg         <= s1_ok_reg;
            read_value_reg <= final_or;
            count_out_reg  <= s1_count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign read_value = read_value_reg;
    assign count      = count_out_reg;
    assign empty_res  = (count_out_reg == '0);

endmodule

// ===== hw/rtl/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell
// One list slot. Holds an entry and, on command, takes its left neighbor
// (insert shift), its right neighbor (remove shift) or the broadcast word.
// ----------------------------------------------------------------------------
module pal_cell
    import pal_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] tap
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_idx;
    logic              past_idx;

    assign at_idx   = (cell_idx == cmd.idx);
    assign past_idx = (cell_idx > cmd.idx);

    // next entry for this slot
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INS:
            begin
                if (at_idx)
                begin
                    data_next = cmd.value;
                end
                else if (past_idx)
                begin
                    data_next = left_data;
                end
            end
            CELL_REM:
            begin
                if (at_idx || past_idx)
                begin
                    data_next = right_data;
                end
            end
            CELL_SET:
            begin
                if (at_idx)
                begin
                    data_next = cmd.value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // read tap: entry shows only when this slot is addressed by a get
    assign tap  = ((cmd.op == CELL_GET) && at_idx) ? data_reg : '0;
    assign data = data_reg;

endmodule

// ===== hw/rtl/pal_checker.sv =====
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks for the positional array list, bound to the top level.
// ----------------------------------------------------------------------------
module pal_checker
    import pal_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     ok,
    input logic signed [DATA_W-1:0] read_value,
    input logic [CNT_W-1:0]         count,
    input logic                     empty_res
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(read_value)
        && $stable(count))
        else $error("result word changed while stalled");

    // a request word waiting for ready stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("request word withdrawn before accept");

    // empty flag follows the reported count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_res == (count == '0)))
        else $error("empty flag disagrees with count");

    // a failed request reads as zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> (read_value == '0))
        else $error("failed request returned data");

    // count never exceeds capacity
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= CNT_W'(CAPACITY)))
        else $error("count beyond capacity");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .read_value (read_value),
    .count      (count),
    .empty_res  (empty_res)
);

// ===== tb/positional_array_list_tb.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_tb
// Self-checking bench for the positional array list. A scoreboard keeps its
// own copy of the list, predicts the result word for every accepted request
// and compares it field by field with what the block returns. A short
// directed run covers the corner cases, then random segments grow, churn and
// drain the list with random gaps on the request side and stalls on the
// result side.
// ----------------------------------------------------------------------------
module positional_array_list_tb
    import pal_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // spare request codes, not decoded by the block
    localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int SEGMENTS     = 11;
    localparam int SEG_WORDS    = 150;
    localparam int IDLE_PERCENT = 26;
    localparam int MAX_REPORTS  = 10;

    // random segment flavors
    typedef enum int {MODE_GROW, MODE_MIXED, MODE_DRAIN} seg_mode_t;

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         count;
        logic                     empty_res;
    } list_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: shadow list plus queue of predicted result words
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic signed [DATA_W-1:0] shadow_slots [CAPACITY];
        int                       shadow_fill;
        list_result_t             expected_results [$];
        int                       errors;
        int                       requests;
        int                       checked;
        int                       rejected;
        int                       full_refusals;

        function new();
            for (int i = 0; i < CAPACITY; i++)
                shadow_slots[i] = '0;
            shadow_fill   = 0;
            errors        = 0;
            requests      = 0;
            checked       = 0;
            rejected      = 0;
            full_refusals = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // apply one accepted request to the shadow list and queue its result
        function void note_request(input logic [ACT_W-1:0] act,
                                   input logic [POS_W-1:0] pos,
                                   input logic signed [DATA_W-1:0] val);
            list_result_t res;
            int           p;
            p              = int'(pos);
            res.ok         = 1'b0;
            res.read_value = '0;
            requests++;
            case (act)
                ACT_INSERT:
                begin
                    if (p >= 1 && p <= shadow_fill + 1 && shadow_fill < CAPACITY)
                    begin
                        for (int i = shadow_fill; i >= p; i--)
                            shadow_slots[i] = shadow_slots[i-1];
                        shadow_slots[p-1] = val;
                        shadow_fill++;
                        res.ok = 1'b1;
                    end
                    else if (shadow_fill == CAPACITY)
                        full_refusals++;
                end
                ACT_REMOVE:
                begin
                    if (p >= 1 && p <= shadow_fill)
                    begin
                        for (int i = p; i < shadow_fill; i++)
                            shadow_slots[i-1] = shadow_slots[i];
                        shadow_fill--;
                        res.ok = 1'b1;
                    end
                end
                ACT_GET:
                begin
                    if (p >= 1 && p <= shadow_fill)
                    begin
                        res.read_value = shadow_slots[p-1];
                        res.ok         = 1'b1;
                    end
                end
                ACT_SET:
                begin
                    if (p >= 1 && p <= shadow_fill)
                    begin
                        shadow_slots[p-1] = val;
                        res.ok            = 1'b1;
                    end
                end
                ACT_CLEAR:
                begin
                    shadow_fill = 0;
                    res.ok      = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (!res.ok)
                rejected++;
            res.count     = CNT_W'(shadow_fill);
            res.empty_res = (shadow_fill == 0);
            expected_results.insert(expected_results.size(), res);
        endfunction

        // compare one returned word with the oldest prediction
        function void check_result(input list_result_t got);
            list_result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] unexpected result word: ok=%0b rd=%0d cnt=%0d",
                             $realtime, got.ok, got.read_value, got.count);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.ok !== want.ok || got.read_value !== want.read_value ||
                got.count !== want.count || got.empty_res !== want.empty_res)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $write("[%0t] word %0d: expected ok=%0b rd=%0d cnt=%0d empty=%0b",
                           $realtime, checked, want.ok, want.read_value, want.count,
                           want.empty_res);
                    $display(", got ok=%0b rd=%0d cnt=%0d empty=%0b",
                             got.ok, got.read_value, got.count, got.empty_res);
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;

    logic                     calm;
    list_scoreboard           sb;

    positional_array_list i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .read_value (read_value),
        .count      (count),
        .empty_res  (empty_res)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("positional_array_list_tb: done, errors");
        $finish;
    end

    // result side back-pressure, changed on the falling edge
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        list_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.ok         = ok;
            got.read_value = read_value;
            got.count      = count;
            got.empty_res  = empty_res;
            sb.check_result(got);
        end
    end

    // present one request word and hold it until accepted; called at a negedge
    task automatic send_word(input logic [ACT_W-1:0] act,
                             input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action   = act;
        position = pos;
        value    = val;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(act, pos, val);
        @(negedge clk);
    endtask

    // request code weighted by segment flavor
    function automatic logic [ACT_W-1:0] pick_action(input seg_mode_t mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            MODE_GROW:
                return (r < 62) ? ACT_INSERT : (r < 72) ? ACT_REMOVE :
                       (r < 86) ? ACT_GET : ACT_SET;
            MODE_DRAIN:
                return (r < 15) ? ACT_INSERT : (r < 70) ? ACT_REMOVE :
                       (r < 85) ? ACT_GET : (r < 97) ? ACT_SET : ACT_CLEAR;
            default:
                return (r < 35) ? ACT_INSERT : (r < 60) ? ACT_REMOVE :
                       (r < 80) ? ACT_GET : (r < 96) ? ACT_SET : ACT_CLEAR;
        endcase
    endfunction

    // mostly legal positions, with zero, just past the end and wild ones mixed in
    function automatic logic [POS_W-1:0] pick_position(input logic [ACT_W-1:0] act,
                                                       input int fill);
        int top;
        int r;
        top = (act == ACT_INSERT) ? fill + 1 : fill;
        if (top < 1)
            top = 1;
        r = $urandom_range(99);
        if (r < 85)
            return POS_W'($urandom_range(top, 1));
        else if (r < 90)
            return '0;
        else if (r < 95)
            return POS_W'(top + 1);
        else
            return POS_W'($urandom_range(255));
    endfunction

    // stimulus
    initial
    begin
        seg_mode_t                mode;
        logic [ACT_W-1:0]         act;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;

        sb       = new();
        calm     = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = ACT_INSERT;
        position = '0;
        value    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list: every positional request is refused, clear still works
        send_word(ACT_GET,    8'd1, 32'sd0);
        send_word(ACT_REMOVE, 8'd1, 32'sd0);
        send_word(ACT_SET,    8'd1, 32'sd5);
        send_word(ACT_CLEAR,  8'd0, 32'sd0);
        send_word(ACT_INSERT, 8'd0, 32'sd1);
        send_word(ACT_INSERT, 8'd2, 32'sd1);
        // build a short list through front, end and middle inserts
        send_word(ACT_INSERT, 8'd1, 32'sh7fffffff);
        send_word(ACT_INSERT, 8'd1, 32'sh80000000);
        send_word(ACT_INSERT, 8'd3, 32'sd0);
        send_word(ACT_INSERT, 8'd2, -32'sd1);
        send_word(ACT_GET,    8'd4, 32'sd0);
        send_word(ACT_GET,    8'd2, 32'sd0);
        send_word(ACT_GET,    8'd5, 32'sd0);
        send_word(ACT_SET,    8'd4, 32'sh55555555);
        send_word(ACT_SET,    8'd5, 32'sh2aaaaaaa);
        send_word(ACT_SET,    8'd0, 32'sd7);
        send_word(ACT_SPARE5, 8'd1, 32'sd9);
        send_word(ACT_SPARE6, 8'd1, 32'sd9);
        send_word(ACT_SPARE7, 8'hff, -32'sd1);
        send_word(ACT_INSERT, 8'hff, 32'sd3);
        send_word(ACT_REMOVE, 8'd1, 32'sd0);
        send_word(ACT_REMOVE, 8'd3, 32'sd0);
        send_word(ACT_GET,    8'd1, 32'sd0);
        send_word(ACT_CLEAR,  8'd0, 32'sd0);
        send_word(ACT_GET,    8'd1, 32'sd0);

        // random segments: grow twice to reach full, then churn and drain
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 4)
                0, 1:    mode = MODE_GROW;
                2:       mode = MODE_MIXED;
                default: mode = MODE_DRAIN;
            endcase
            calm = (seg == 4);
            for (int n = 0; n < SEG_WORDS; n++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    act = ACT_W'($urandom_range(7));
                    pos = POS_W'($urandom_range(255));
                end
                else
                begin
                    act = pick_action(mode);
                    pos = pick_position(act, sb.shadow_fill);
                end
                val = $urandom;
                send_word(act, pos, val);
            end
        end
        calm     = 1'b0;
        in_valid = 1'b0;

        // drain, then allow for the two-stage result pipeline
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("requests %0d, result words checked %0d, refused %0d",
                 sb.requests, sb.checked, sb.rejected);
        $display("inserts refused on a full list %0d, mismatches %0d",
                 sb.full_refusals, sb.errors);
        if (sb.errors == 0)
            $display("positional_array_list_tb: done, clean");
        else
            $display("positional_array_list_tb: done, errors");
        $finish;
    end

endmodule
